// File: rtl/core/hsl2rgb_pkg.sv
package hsl2rgb_pkg;

    // Input formats
    localparam int unsigned HUE_W  = 16;
    localparam int unsigned UNIT_W = 13;
    localparam int unsigned T_W    = 13;
    localparam int unsigned PROD_W = 25;   // a * s, at most 4096 * 4096
    localparam int unsigned NUM_W  = 38;   // numerators over 15 * 2^33
    localparam int unsigned SEC_W  = 3;

    localparam logic [HUE_W-1:0]  HUE_FULL   = 16'd46080;   // 360 degrees
    localparam logic [HUE_W-1:0]  HUE_SECTOR = 16'd7680;    // 60 degrees
    localparam logic [UNIT_W-1:0] UNIT_ONE   = 13'd4096;    // 1.0

    // Full-scale numerator: a channel of exactly 1.0 (15 * 2^33)
    localparam logic [NUM_W-1:0]  NUM_FULL   = 38'd128849018880;

    // Hue sectors, 60 degrees each
    localparam logic [SEC_W-1:0] SEC_RED_YEL = 3'd0;
    localparam logic [SEC_W-1:0] SEC_YEL_GRN = 3'd1;
    localparam logic [SEC_W-1:0] SEC_GRN_CYN = 3'd2;
    localparam logic [SEC_W-1:0] SEC_CYN_BLU = 3'd3;
    localparam logic [SEC_W-1:0] SEC_BLU_MAG = 3'd4;
    localparam logic [SEC_W-1:0] SEC_MAG_RED = 3'd5;

    // Input beat
    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [UNIT_W-1:0] saturation;
        logic [UNIT_W-1:0] lightness;
    } pixel_t;

    // Output beat
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       range_error;
    } rgb_t;

    // After hue decode
    typedef struct packed {
        logic              err;
        logic [SEC_W-1:0]  sector;
        logic [T_W-1:0]    t;
        logic [UNIT_W-1:0] a;
        logic [UNIT_W-1:0] sat;
        logic [UNIT_W-1:0] lit;
    } decode_t;

    // After a * s
    typedef struct packed {
        logic              err;
        logic [SEC_W-1:0]  sector;
        logic [T_W-1:0]    t;
        logic [UNIT_W-1:0] lit;
        logic [PROD_W-1:0] prod;
    } chroma_t;

    // Chroma, second component and offset numerators
    typedef struct packed {
        logic             err;
        logic [SEC_W-1:0] sector;
        logic [NUM_W-1:0] cn;
        logic [NUM_W-1:0] xn;
        logic [NUM_W-1:0] mn;
    } terms_t;

    // Per-channel numerators
    typedef struct packed {
        logic             err;
        logic [NUM_W-1:0] rn;
        logic [NUM_W-1:0] gn;
        logic [NUM_W-1:0] bn;
    } sum_t;

endpackage

// File: rtl/core/hsl_to_rgb_converter_unit.sv
// HSL to RGB pixel converter.
// Input channel pixel_valid / pixel_stall / pixel carries one HSL beat:
// hue in 1/128 degree (46080 = 360 degrees), saturation and lightness in
// unsigned 1.12 (4096 = 1.0). Output channel rgb_valid / rgb_stall / rgb
// returns one beat per pixel: 8-bit red, green, blue, rounded half up, plus
// range_error when any input is out of range (channels then read zero).
// Hue of exactly 360 degrees is treated as 0.
// Five register stages: hue decode, a * s, product terms, channel mix,
// scale to 8 bits. One beat per cycle is sustained while rgb_stall is
// low; every stage, the two multiplier stages too, is one beat wide.
// Every stage keeps its own valid bit, so bubbles close up: while rgb_stall
// holds, earlier stages keep filling and pixel_stall rises only when all
// five stages hold a beat. Stalled beats hold their values.
// Reset clears all valid bits; no beat is presented until a pixel arrives.
module hsl_to_rgb_converter_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pixel_valid,
    output logic                pixel_stall,
    input  hsl2rgb_pkg::pixel_t pixel,
    output logic                rgb_valid,
    input  logic                rgb_stall,
    output hsl2rgb_pkg::rgb_t   rgb
);
    import hsl2rgb_pkg::*;

    chroma_t chroma;
    terms_t  terms;
    logic    chroma_valid, chroma_stall;
    logic    terms_valid, terms_stall;

    hsl2rgb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .chroma_valid (chroma_valid),
        .chroma_stall (chroma_stall),
        .chroma       (chroma)
    );

    hsl2rgb_terms u_terms (
        .clk          (clk),
        .rst_n        (rst_n),
        .chroma_valid (chroma_valid),
        .chroma_stall (chroma_stall),
        .chroma       (chroma),
        .terms_valid  (terms_valid),
        .terms_stall  (terms_stall),
        .terms        (terms)
    );

    hsl2rgb_scale u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .terms_valid  (terms_valid),
        .terms_stall  (terms_stall),
        .terms        (terms),
        .rgb_valid    (rgb_valid),
        .rgb_stall    (rgb_stall),
        .rgb          (rgb)
    );

endmodule

// File: rtl/core/hsl2rgb_front.sv
module hsl2rgb_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pixel_valid,
    output logic                pixel_stall,
    input  hsl2rgb_pkg::pixel_t  pixel,
    output logic                chroma_valid,
    input  logic                chroma_stall,
    output hsl2rgb_pkg::chroma_t chroma
);
    import hsl2rgb_pkg::*;

    decode_t           dec_next, dec_reg;
    chroma_t           chr_next, chr_reg;
    logic              dec_valid_next, dec_valid_reg;
    logic              chr_valid_next, chr_valid_reg;
    logic              dec_ready, chr_ready;
    logic [HUE_W-1:0]  hue_wrap;
    logic [HUE_W-1:0]  hue_base;
    logic [HUE_W-1:0]  hue_rem;
    logic [UNIT_W:0]   two_l;
    logic [UNIT_W:0]   a_wide;
    logic [2*UNIT_W-1:0] prod_wide;

    // Stage handshake: a stage loads when empty or when its beat moves on
    assign chr_ready   = !chr_valid_reg || !chroma_stall;
    assign dec_ready   = !dec_valid_reg || chr_ready;
    assign pixel_stall = !dec_ready;

    assign dec_valid_next = dec_ready ? pixel_valid   : dec_valid_reg;
    assign chr_valid_next = chr_ready ? dec_valid_reg : chr_valid_reg;

    // Stage 1: range check, sector split, distance to sector edge, 1 - |2L - 1|
    always_comb
    begin
        hue_wrap = (pixel.hue == HUE_FULL) ? '0 : pixel.hue;

        if (hue_wrap < HUE_SECTOR)
        begin
            dec_next.sector = SEC_RED_YEL;
            hue_base        = '0;
        end
        else if (hue_wrap < 16'(2 * HUE_SECTOR))
        begin
            dec_next.sector = SEC_YEL_GRN;
            hue_base        = HUE_SECTOR;
        end
        else if (hue_wrap < 16'(3 * HUE_SECTOR))
        begin
            dec_next.sector = SEC_GRN_CYN;
            hue_base        = 16'(2 * HUE_SECTOR);
        end
        else if (hue_wrap < 16'(4 * HUE_SECTOR))
        begin
            dec_next.sector = SEC_CYN_BLU;
            hue_base        = 16'(3 * HUE_SECTOR);
        end
        else if (hue_wrap < 16'(5 * HUE_SECTOR))
        begin
            dec_next.sector = SEC_BLU_MAG;
            hue_base        = 16'(4 * HUE_SECTOR);
        end
        else
        begin
            dec_next.sector = SEC_MAG_RED;
            hue_base        = 16'(5 * HUE_SECTOR);
        end

        hue_rem    = hue_wrap - hue_base;
        dec_next.t = dec_next.sector[0] ? T_W'(HUE_SECTOR - hue_rem) : hue_rem[T_W-1:0];

        two_l  = {pixel.lightness, 1'b0};
        a_wide = (two_l >= {1'b0, UNIT_ONE}) ? ({UNIT_ONE, 1'b0} - two_l) : two_l;

        dec_next.a   = a_wide[UNIT_W-1:0];
        dec_next.sat = pixel.saturation;
        dec_next.lit = pixel.lightness;
        dec_next.err = (pixel.hue > HUE_FULL) || (pixel.saturation > UNIT_ONE)
                    || (pixel.lightness > UNIT_ONE);
    end

    // Stage 2: a * s
    assign prod_wide = (2*UNIT_W)'(dec_reg.a) * (2*UNIT_W)'(dec_reg.sat);

    always_comb
    begin
        chr_next.err    = dec_reg.err;
        chr_next.sector = dec_reg.sector;
        chr_next.t      = dec_reg.t;
        chr_next.lit    = dec_reg.lit;
        chr_next.prod   = prod_wide[PROD_W-1:0];
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_valid_reg <= 1'b0;
            chr_valid_reg <= 1'b0;
        end
        else
        begin
            dec_valid_reg <= dec_valid_next;
            chr_valid_reg <= chr_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (dec_ready && pixel_valid)
        begin
            dec_reg <= dec_next;
        end
        if (chr_ready && dec_valid_reg)
        begin
            chr_reg <= chr_next;
        end
    end

    assign chroma_valid = chr_valid_reg;
    assign chroma       = chr_reg;

`ifndef ASSERT_OFF
    // In-range beats decode to a real sector and a distance within one sector
    a_sector_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (dec_valid_reg && !dec_reg.err) |->
            ((dec_reg.sector <= SEC_MAG_RED) && (dec_reg.t <= T_W'(HUE_SECTOR))))
        else $error("hue decode out of range");
`endif

endmodule

// File: rtl/core/hsl2rgb_terms.sv
module hsl2rgb_terms (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 chroma_valid,
    output logic                 chroma_stall,
    input  hsl2rgb_pkg::chroma_t chroma,
    output logic                 terms_valid,
    input  logic                 terms_stall,
    output hsl2rgb_pkg::terms_t  terms
);
    import hsl2rgb_pkg::*;

    terms_t                  trm_next, trm_reg;
    logic                    trm_valid_next, trm_valid_reg;
    logic                    trm_ready;
    logic [PROD_W:0]         l_minus;
    logic [NUM_W-1:0]        prod_ext;
    logic [NUM_W-1:0]        diff_ext;

    assign trm_ready      = !trm_valid_reg || !terms_stall;
    assign chroma_stall   = !trm_ready;
    assign trm_valid_next = trm_ready ? chroma_valid : trm_valid_reg;

    // Stage 3: X = as * t, C = as * 7680, M = 3840 * (8192 l - as)
    always_comb
    begin
        prod_ext = NUM_W'(chroma.prod);
        l_minus  = {chroma.lit, 13'b0} - (PROD_W+1)'(chroma.prod);
        diff_ext = NUM_W'(l_minus);

        trm_next.err    = chroma.err;
        trm_next.sector = chroma.sector;
        trm_next.xn     = prod_ext * NUM_W'(chroma.t);
        trm_next.cn     = (prod_ext << 13) - (prod_ext << 9);
        trm_next.mn     = (diff_ext << 12) - (diff_ext << 8);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trm_valid_reg <= 1'b0;
        end
        else
        begin
            trm_valid_reg <= trm_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (trm_ready && chroma_valid)
        begin
            trm_reg <= trm_next;
        end
    end

    assign terms_valid = trm_valid_reg;
    assign terms       = trm_reg;

`ifndef ASSERT_OFF
    // Second component never exceeds chroma
    a_x_le_c: assert property (@(posedge clk) disable iff (!rst_n)
        (trm_valid_reg && !trm_reg.err) |-> (trm_reg.xn <= trm_reg.cn))
        else $error("X above chroma");
`endif

endmodule

// File: rtl/core/hsl2rgb_scale.sv
module hsl2rgb_scale (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                terms_valid,
    output logic                terms_stall,
    input  hsl2rgb_pkg::terms_t terms,
    output logic                rgb_valid,
    input  logic                rgb_stall,
    output hsl2rgb_pkg::rgb_t   rgb
);
    import hsl2rgb_pkg::*;

    sum_t       sum_next, sum_reg;
    rgb_t       out_next, out_reg;
    logic       sum_valid_next, sum_valid_reg;
    logic       out_valid_next, out_valid_reg;
    logic       sum_ready, out_ready;
    logic [NUM_W-1:0] v_c, v_x;

    // round(num * 255 / (15 * 2^33)) = (17 * num + 2^32) >> 33, clamped
    function automatic logic [7:0] to_channel(input logic [NUM_W-1:0] num);
        logic [NUM_W+4:0] wide;
        logic [9:0]       q;
        wide = ((NUM_W+5)'(num) << 4) + (NUM_W+5)'(num) + ((NUM_W+5)'(1) << 32);
        q    = wide[NUM_W+4:33];
        return (q > 10'd255) ? 8'd255 : q[7:0];
    endfunction

    assign out_ready      = !out_valid_reg || !rgb_stall;
    assign sum_ready      = !sum_valid_reg || out_ready;
    assign terms_stall    = !sum_ready;
    assign sum_valid_next = sum_ready ? terms_valid   : sum_valid_reg;
    assign out_valid_next = out_ready ? sum_valid_reg : out_valid_reg;

    // Stage 4: channel order by sector, add offset
    always_comb
    begin
        v_c = terms.cn + terms.mn;
        v_x = terms.xn + terms.mn;
        sum_next.err = terms.err;
        case (terms.sector)
            SEC_RED_YEL:
            begin
                sum_next.rn = v_c;      sum_next.gn = v_x;      sum_next.bn = terms.mn;
            end
            SEC_YEL_GRN:
            begin
                sum_next.rn = v_x;      sum_next.gn = v_c;      sum_next.bn = terms.mn;
            end
            SEC_GRN_CYN:
            begin
                sum_next.rn = terms.mn; sum_next.gn = v_c;      sum_next.bn = v_x;
            end
            SEC_CYN_BLU:
            begin
                sum_next.rn = terms.mn; sum_next.gn = v_x;      sum_next.bn = v_c;
            end
            SEC_BLU_MAG:
            begin
                sum_next.rn = v_x;      sum_next.gn = terms.mn; sum_next.bn = v_c;
            end
            default:
            begin
                sum_next.rn = v_c;      sum_next.gn = terms.mn; sum_next.bn = v_x;
            end
        endcase
    end

    // Stage 5: scale to 8 bits, zero on range error
    always_comb
    begin
        out_next.range_error = sum_reg.err;
        out_next.red   = sum_reg.err ? 8'd0 : to_channel(sum_reg.rn);
        out_next.green = sum_reg.err ? 8'd0 : to_channel(sum_reg.gn);
        out_next.blue  = sum_reg.err ? 8'd0 : to_channel(sum_reg.bn);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_valid_reg <= sum_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_ready && terms_valid)
        begin
            sum_reg <= sum_next;
        end
        if (out_ready && sum_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign rgb_valid = out_valid_reg;
    assign rgb       = out_reg;

`ifndef ASSERT_OFF
    // In-range channel numerators never pass full scale
    a_sum_full: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_valid_reg && !sum_reg.err) |->
            ((sum_reg.rn <= NUM_FULL) && (sum_reg.gn <= NUM_FULL)
             && (sum_reg.bn <= NUM_FULL)))
        else $error("channel numerator above full scale");

    // A range error leaves the stage as a black beat
    a_err_black: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_valid_reg && sum_reg.err && out_ready) |=>
            (rgb_valid && rgb.range_error && (rgb.red == 8'd0)
             && (rgb.green == 8'd0) && (rgb.blue == 8'd0)))
        else $error("range error beat carries color");
`endif

endmodule

// File: sim/tb_hsl_to_rgb_converter_unit.sv
module tb_hsl_to_rgb_converter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import hsl2rgb_pkg::*;

    localparam int unsigned RANDOM_PIXELS  = 1200;
    localparam int unsigned BACKLOG_PIXELS = 30;
    localparam int unsigned HOLD_CYCLES    = 80;
    localparam int unsigned DRAIN_CYCLES   = 12;
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    // Receiver stall patterns
    typedef enum int unsigned {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } stall_mode_t;

    // Expected-color store: predicts each pixel's RGB and checks returned beats
    class rgb_scoreboard;
        rgb_t        expected_rgb_q[$];
        int unsigned mismatches;

        // channel = (num * 255) / (2 * 4096 * 4096 * 7680), rounded half up
        function logic [7:0] scale_channel(longint unsigned num);
            longint unsigned den;
            longint unsigned v;
            den = 64'd2 * 64'd4096 * 64'd4096 * 64'(HUE_SECTOR);
            v = (num * 64'd255 + den / 64'd2) / den;
            return (v > 64'd255) ? 8'd255 : v[7:0];
        endfunction

        function rgb_t convert_pixel(pixel_t p);
            rgb_t             r;
            longint unsigned  h, s, l, rem, t, a, prod, cn, xn, mn, rn, gn, bn;
            logic [SEC_W-1:0] sector;
            r = '0;
            h = p.hue;
            s = p.saturation;
            l = p.lightness;
            if (h > HUE_FULL || s > UNIT_ONE || l > UNIT_ONE) begin
                r.range_error = 1'b1;
                return r;
            end
            // 360 degrees folds onto red
            if (h == HUE_FULL)
                h = 0;
            sector = SEC_W'(h / HUE_SECTOR);
            rem    = h % HUE_SECTOR;
            t      = sector[0] ? (HUE_SECTOR - rem) : rem;
            // a = 1 - |2L - 1| in 1.12 units
            a    = (2 * l >= UNIT_ONE) ? (2 * UNIT_ONE - 2 * l) : 2 * l;
            prod = a * s;
            cn   = prod * 2 * HUE_SECTOR;
            xn   = prod * t * 2;
            mn   = l * 2 * UNIT_ONE * HUE_SECTOR - prod * HUE_SECTOR;
            case (sector)
                SEC_RED_YEL: begin rn = cn; gn = xn; bn = 0;  end
                SEC_YEL_GRN: begin rn = xn; gn = cn; bn = 0;  end
                SEC_GRN_CYN: begin rn = 0;  gn = cn; bn = xn; end
                SEC_CYN_BLU: begin rn = 0;  gn = xn; bn = cn; end
                SEC_BLU_MAG: begin rn = xn; gn = 0;  bn = cn; end
                default:     begin rn = cn; gn = 0;  bn = xn; end
            endcase
            r.red   = scale_channel(rn + mn);
            r.green = scale_channel(gn + mn);
            r.blue  = scale_channel(bn + mn);
            return r;
        endfunction

        function void note_pixel(pixel_t p);
            expected_rgb_q.push_back(convert_pixel(p));
        endfunction

        function void check_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                mismatches++;
                $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
            end
        endfunction

        function void check_rgb(rgb_t got);
            rgb_t want;
            if (expected_rgb_q.size() == 0) begin
                mismatches++;
                $display("%0t: rgb beat with nothing expected, actual %p", $time, got);
                return;
            end
            want = expected_rgb_q.pop_front();
            check_field("red", want.red, got.red);
            check_field("green", want.green, got.green);
            check_field("blue", want.blue, got.blue);
            check_field("range_error", want.range_error, got.range_error);
        endfunction

        function int unsigned pending();
            return expected_rgb_q.size();
        endfunction
    endclass

    logic   clk;
    logic   rst_n;
    logic   pixel_valid;
    logic   pixel_stall;
    pixel_t pixel;
    logic   rgb_valid;
    logic   rgb_stall;
    rgb_t   rgb;

    rgb_scoreboard sb;
    int unsigned   beats_seen;
    bit            hold_req;

    hsl_to_rgb_converter_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .rgb_valid   (rgb_valid),
        .rgb_stall   (rgb_stall),
        .rgb         (rgb)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Inputs only move at rising edges, so mid-cycle values are the ones the
    // next edge will see
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (pixel_valid && !pixel_stall) begin
                sb.note_pixel(pixel);
                beats_seen++;
            end
            if (rgb_valid && !rgb_stall) begin
                sb.check_rgb(rgb);
                beats_seen++;
            end
        end
    end

    // Saturation / lightness: mostly legal, some edges, some out of range
    function automatic logic [UNIT_W-1:0] pick_unit();
        int unsigned sel;
        int unsigned edges[7];
        edges = '{0, 1, 2047, 2048, 2049, 4095, 4096};
        sel = $urandom_range(0, 99);
        if (sel < 8)
            return UNIT_W'($urandom_range(4097, 8191));
        if (sel < 16)
            return UNIT_W'(edges[$urandom_range(0, 6)]);
        return UNIT_W'($urandom_range(0, 4096));
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t      p;
        int unsigned sel;
        int unsigned h;
        sel = $urandom_range(0, 99);
        if (sel < 8)
            h = $urandom_range(46081, 65535);
        else if (sel < 16) begin
            // one step either side of a sector boundary
            h = $urandom_range(0, 6) * HUE_SECTOR + $urandom_range(0, 2);
            h = (h == 0) ? 0 : h - 1;
        end
        else
            h = $urandom_range(0, 46080);
        p.hue        = HUE_W'(h);
        p.saturation = pick_unit();
        p.lightness  = pick_unit();
        return p;
    endfunction

    // Offer one beat and hold it until taken; returns at the accepting edge
    task automatic send_pixel(input pixel_t p);
        pixel_valid <= 1'b1;
        pixel       <= p;
        do @(negedge clk); while (pixel_stall);
        @(posedge clk);
    endtask

    task automatic send_hsl(input int unsigned h, input int unsigned s, input int unsigned l);
        pixel_t p;
        p.hue        = HUE_W'(h);
        p.saturation = UNIT_W'(s);
        p.lightness  = UNIT_W'(l);
        send_pixel(p);
    endtask

    task automatic idle_input(input int unsigned cycles);
        pixel_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Receiver: stall pattern changes per segment, plus one long hold-off
    initial
    begin
        stall_mode_t mode;
        int unsigned seg_left;
        int unsigned hold_left;
        mode      = STALL_NONE;
        seg_left  = 0;
        hold_left = 0;
        rgb_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req  <= 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rgb_stall <= 1'b1;
            end
            else begin
                if (seg_left == 0) begin
                    mode     = stall_mode_t'($urandom_range(0, 3));
                    seg_left = $urandom_range(8, 60);
                end
                seg_left--;
                case (mode)
                    STALL_NONE:   rgb_stall <= 1'b0;
                    STALL_LIGHT:  rgb_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:  rgb_stall <= ($urandom_range(0, 3) != 0);
                    STALL_TOGGLE: rgb_stall <= ~rgb_stall;
                    default:      rgb_stall <= 1'b0;
                endcase
            end
        end
    end

    // Watchdog: ends the run after a long stretch with no beat on either side
    initial
    begin
        int unsigned quiet;
        int unsigned last_seen;
        quiet     = 0;
        last_seen = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (beats_seen != last_seen) begin
                quiet     = 0;
                last_seen = beats_seen;
            end
            else
                quiet++;
        end
        $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb_hsl_to_rgb_converter_unit: done, errors");
        $finish;
    end

    // Main sequence
    initial
    begin
        int unsigned sent;
        int unsigned burst;
        sb          = new;
        beats_seen  = 0;
        hold_req    = 1'b0;
        rst_n       <= 1'b0;
        pixel_valid <= 1'b0;
        pixel       <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: every sector, 360 wrap, extremes, halfway rounding, errors
        send_hsl(0,     4096, 2048);
        send_hsl(7680,  4096, 2048);
        send_hsl(15360, 4096, 2048);
        send_hsl(23040, 4096, 2048);
        send_hsl(30720, 4096, 2048);
        send_hsl(38400, 4096, 2048);
        send_hsl(3840,  4096, 2048);
        send_hsl(11520, 4096, 1024);
        send_hsl(27000, 1234, 2900);
        send_hsl(42240, 3000, 3000);
        send_hsl(46080, 4096, 2048);
        send_hsl(46079, 4096, 2048);
        send_hsl(0,     0,    2048);  // gray 127.5 rounds up
        send_hsl(0,     0,    0);
        send_hsl(0,     0,    4096);
        send_hsl(0,     4096, 4096);
        send_hsl(0,     4096, 0);
        send_hsl(46081, 0,    0);
        send_hsl(65535, 8191, 8191);
        send_hsl(0,     4097, 0);
        send_hsl(0,     0,    4097);
        send_hsl(0,     8191, 2048);
        send_hsl(0,     2048, 8191);
        idle_input($urandom_range(1, 8));

        // Back up the pipe: long receiver hold while input keeps offering
        hold_req <= 1'b1;
        repeat (BACKLOG_PIXELS) send_pixel(random_pixel());

        // Random bursts with random gaps
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                send_pixel(random_pixel());
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                idle_input($urandom_range(1, 8));
        end

        // Drain
        pixel_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_hsl_to_rgb_converter_unit: done, clean");
        else
            $display("tb_hsl_to_rgb_converter_unit: done, errors");
        $finish;
    end

endmodule
